@@ rtl/pfe_pkg.sv @@
package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

  // per-cycle command to every stack cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    logic underflow;
    logic divide_by_zero;
    logic overflowed;
  } err_flags_t;

  function automatic logic is_operator(input logic [SYM_W-1:0] sym);
    return (sym == SYM_ADD) || (sym == SYM_SUB) || (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

endpackage

@@ rtl/pfe_cell.sv @@
// one stack entry; push takes the entry above, pop takes the entry below
module pfe_cell import pfe_pkg::*; (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] from_up,
  input  logic [DATA_W-1:0] from_down,
  output logic [DATA_W-1:0] val
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_PUSH: val <= from_up;
      CMD_POP:  val <= from_down;
      CMD_HOLD: val <= val;
      default:  val <= val;
    endcase
  end

endmodule

@@ rtl/pfe_div.sv @@
// signed divide, truncating toward zero; one quotient bit per cycle
module pfe_div import pfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Sequence: a pushed character goes from the transfer to ST_PUSH; + - * and / by 0 first pass
//   ST_POP_R, ST_POP_L and ST_EXEC, and any other / adds ST_DIV_WAIT on the shift-subtract divider.
// Flow: one character at a time, taken only in ST_IDLE after the pop/execute/push sequence on the
//   cell chain and the divider, plus ST_FINAL and any result stall on the last character.
// Reset (rst, synchronous, active high): stack empty, error flags clear, no result pending.
//   Stack cells hold no reset; only entries below the count are ever read.
module postfix_expression_evaluator import pfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] symbol
  input  logic              s_axis_tlast,   // last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] value
  output logic [2:0]        m_axis_tuser    // [0] underflow, [1] divide_by_zero, [2] overflowed
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_R,
    ST_POP_L,
    ST_EXEC,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_FINAL
  } state_t;

  state_t            state;
  logic [SYM_W-1:0]  sym;
  logic              last;
  logic [CNT_W-1:0]  count;
  err_flags_t        flags;
  logic [DATA_W-1:0] left;
  logic [DATA_W-1:0] right;
  logic [DATA_W-1:0] res;
  cell_cmd_t         cmd;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic              empty;
  logic              full;
  logic              result_load;
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] cell_val [STACK_DEPTH];

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(STACK_DEPTH));
  // empty stack pops as zero
  assign top   = empty ? '0 : cell_val[0];

  assign s_axis_tready = (state == ST_IDLE);
  assign div_start     = (state == ST_EXEC) && (sym == SYM_DIV) && (right != '0);
  // result register takes the final pop once it is free or being drained
  assign result_load   = (state == ST_FINAL) && (!m_axis_tvalid || m_axis_tready);

  // stack shifts down on push, up on pop; cell 0 is the top
  always_comb begin
    cmd = CMD_HOLD;
    unique case (state)
      ST_POP_R, ST_POP_L: if (!empty) begin
        cmd = CMD_POP;
      end
      ST_PUSH: if (!full) begin
        cmd = CMD_PUSH;
      end
      default: cmd = CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] down;
    if (i == 0) begin : g_top
      assign up = res;
    end else begin : g_mid
      assign up = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down = '0;
    end else begin : g_inner
      assign down = cell_val[i+1];
    end
    pfe_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .from_up   (up),
      .from_down (down),
      .val       (cell_val[i])
    );
  end

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left),
    .divisor  (right),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      flags         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (result_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          sym  <= s_axis_tdata;
          last <= s_axis_tlast;
          // plain characters push code minus '0', wrapped
          res  <= {{(DATA_W-SYM_W){1'b0}}, s_axis_tdata} - {{(DATA_W-SYM_W){1'b0}}, SYM_ZERO};
          state <= is_operator(s_axis_tdata) ? ST_POP_R : ST_PUSH;
        end
        ST_POP_R: begin
          right <= top;
          if (empty) begin
            flags.underflow <= 1'b1;
          end else begin
            count <= count - CNT_W'(1);
          end
          state <= ST_POP_L;
        end
        ST_POP_L: begin
          left <= top;
          if (empty) begin
            flags.underflow <= 1'b1;
          end else begin
            count <= count - CNT_W'(1);
          end
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          priority if (sym == SYM_ADD) begin
            res   <= left + right;
            state <= ST_PUSH;
          end else if (sym == SYM_SUB) begin
            res   <= left - right;
            state <= ST_PUSH;
          end else if (sym == SYM_MUL) begin
            res   <= DATA_W'(left * right);
            state <= ST_PUSH;
          end else if (right == '0) begin
            res                  <= '0;
            flags.divide_by_zero <= 1'b1;
            state                <= ST_PUSH;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: if (div_done) begin
          res   <= div_quot;
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (full) begin
            flags.overflowed <= 1'b1;
          end else begin
            count <= count + CNT_W'(1);
          end
          state <= last ? ST_FINAL : ST_IDLE;
        end
        ST_FINAL: if (result_load) begin
          // final pop; an empty stack here also counts as underflow
          m_axis_tdata    <= top;
          m_axis_tuser[0] <= flags.underflow | empty;
          m_axis_tuser[1] <= flags.divide_by_zero;
          m_axis_tuser[2] <= flags.overflowed;
          count           <= '0;
          flags           <= '0;
          state           <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top import pfe_pkg::*; ();

  typedef logic [7:0] sym_q_t[$];

  typedef enum {
    EXPR_FORMED,
    EXPR_BROKEN,
    EXPR_NOISE,
    EXPR_FLOOD
  } expr_kind_t;

  typedef struct {
    logic [31:0] value;
    logic        underflow;
    logic        divide_by_zero;
    logic        overflowed;
  } eval_result_t;

  // Mirror of the operand stack. Works out the emitted value and sticky flags
  // for every accepted symbol and checks the block's results in order.
  class rpn_scoreboard;
    logic [31:0]  operands[STACK_DEPTH];
    int           used;
    logic         under_seen, divz_seen, over_seen;
    eval_result_t pending_results[$];
    int           fail_count;

    function new();
      used       = 0;
      under_seen = 1'b0;
      divz_seen  = 1'b0;
      over_seen  = 1'b0;
      fail_count = 0;
    endfunction

    function void push_operand(logic [31:0] v);
      if (used < STACK_DEPTH) begin
        operands[used] = v;
        used++;
      end else begin
        over_seen = 1'b1;
      end
    endfunction

    function logic [31:0] pop_operand();
      if (used == 0) begin
        under_seen = 1'b1;
        return '0;
      end
      used--;
      return operands[used];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Called on every accepted input transfer.
    function void note_symbol(logic [7:0] sym, logic lst);
      logic [31:0]  lhs, rhs, res, mag_l, mag_r, quo;
      eval_result_t want;
      case (sym)
        SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
          rhs = pop_operand();
          lhs = pop_operand();
          case (sym)
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            SYM_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                divz_seen = 1'b1;
                res       = '0;
              end else begin
                // magnitude divide, sign fixed afterwards; min / -1 wraps back to min
                mag_l = lhs[31] ? -lhs : lhs;
                mag_r = rhs[31] ? -rhs : rhs;
                quo   = mag_l / mag_r;
                res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
              end
            end
          endcase
          push_operand(res);
        end
        default: push_operand({24'd0, sym} - {24'd0, SYM_ZERO});
      endcase
      if (lst) begin
        // final symbol's own flags land in this result
        want.value          = pop_operand();
        want.underflow      = under_seen;
        want.divide_by_zero = divz_seen;
        want.overflowed     = over_seen;
        pending_results.push_back(want);
        used       = 0;
        under_seen = 1'b0;
        divz_seen  = 1'b0;
        over_seen  = 1'b0;
      end
    endfunction

    // Called on every accepted output transfer.
    function void check_result(logic [31:0] value, logic [2:0] flags);
      eval_result_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result with no expression pending: value %0d flags %b",
               $signed(value), flags);
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        fail_count++;
        $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
      end
      if (flags[0] !== want.underflow) begin
        fail_count++;
        $error("underflow: expected %b, got %b", want.underflow, flags[0]);
      end
      if (flags[1] !== want.divide_by_zero) begin
        fail_count++;
        $error("divide_by_zero: expected %b, got %b", want.divide_by_zero, flags[1]);
      end
      if (flags[2] !== want.overflowed) begin
        fail_count++;
        $error("overflowed: expected %b, got %b", want.overflowed, flags[2]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic        s_axis_tlast = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] value
  logic [2:0]  m_axis_tuser;        // [0] underflow, [1] divide_by_zero, [2] overflowed

  rpn_scoreboard rpn_sb = new();
  int            items_sent = 0;
  bit            no_gaps = 1'b0;    // both sides run flat out while set

  postfix_expression_evaluator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // One symbol transfer. tvalid is only dropped when a gap is drawn, so a
  // back-to-back transfer never sees a low and a high in the same step.
  task automatic send_symbol(input logic [7:0] sym, input logic lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    rpn_sb.note_symbol(sym, lst);
    items_sent++;
  endtask

  // Sends a whole expression, tlast on its final symbol.
  task automatic send_run(input sym_q_t run);
    foreach (run[i]) send_symbol(run[i], i == run.size() - 1);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rpn_sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_ADD;
      1:       return SYM_SUB;
      2:       return SYM_MUL;
      default: return SYM_DIV;
    endcase
  endfunction

  // Mostly digits; now and then any other non-operator byte.
  function automatic logic [7:0] pick_operand();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 85)
      return SYM_ZERO + 8'($urandom_range(0, 9));
    do b = 8'($urandom);
    while (b == SYM_ADD || b == SYM_SUB || b == SYM_MUL || b == SYM_DIV);
    return b;
  endfunction

  // Formed: valid postfix with random content. Flood: all operands first,
  // 62 to 72 of them, mostly enough to run off the 64-entry stack. Broken: a formed one
  // with a symbol dropped or a stray operator spliced in. Noise: any bytes.
  task automatic send_expression(input expr_kind_t kind);
    sym_q_t run;
    int     operands_left, depth, idx;
    run = {};
    if (kind == EXPR_NOISE) begin
      repeat ($urandom_range(1, 6)) run.push_back(8'($urandom));
    end else begin
      operands_left = (kind == EXPR_FLOOD) ? $urandom_range(62, 72) : $urandom_range(1, 7);
      depth = 0;
      while (operands_left > 0 || depth > 1) begin
        if (depth >= 2 && (operands_left == 0 ||
            (kind != EXPR_FLOOD && $urandom_range(0, 2) == 0))) begin
          run.push_back(pick_operator());
          depth--;
        end else begin
          run.push_back(pick_operand());
          depth++;
          operands_left--;
        end
      end
      if (kind == EXPR_BROKEN) begin
        idx = $urandom_range(0, run.size() - 1);
        if ($urandom_range(0, 1)) run.delete(idx);
        else run.insert(idx, pick_operator());
        if (run.size() == 0) run.push_back(pick_operator());
      end
    end
    send_run(run);
  endtask

  // Result side: random stall before each result, none in steady stretches.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      rpn_sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    sym_q_t     run;
    int         roll;
    bit         mid_drained;
    expr_kind_t kind;
    mid_drained = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both byte extremes pushed as non-digits: -48 + 207
    run = '{8'h00, 8'hFF, SYM_ADD};
    send_run(run);
    // negative difference, then a division truncated toward zero: (3-9)/4 = -1
    run = '{SYM_ZERO + 8'd3, SYM_ZERO + 8'd9, SYM_SUB, SYM_ZERO + 8'd4, SYM_DIV};
    send_run(run);
    // zero divisor
    run = '{SYM_ZERO + 8'd5, SYM_ZERO, SYM_DIV};
    send_run(run);
    // lone operator on an empty stack: underflow and zero divisor together
    run = '{SYM_DIV};
    send_run(run);
    // build 2^31 ('p' pushes 64, 176 pushes 128), then divide by 0-1
    run = '{8'd112, 8'd112, SYM_MUL, 8'd112, SYM_MUL, 8'd112, SYM_MUL,
            8'd176, SYM_MUL, SYM_ZERO, SYM_ZERO + 8'd1, SYM_SUB, SYM_DIV};
    send_run(run);
    wait_drained();

    send_expression(EXPR_FLOOD);
    while (items_sent < 900) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      roll = $urandom_range(0, 99);
      if (roll < 70)      kind = EXPR_FORMED;
      else if (roll < 84) kind = EXPR_BROKEN;
      else if (roll < 98) kind = EXPR_NOISE;
      else                kind = EXPR_FLOOD;
      send_expression(kind);
      if (!mid_drained && items_sent > 450) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end

    wait_drained();
    // longest item is a divide; leave room for strays
    repeat (60) @(posedge clk);
    if (rpn_sb.fail_count == 0 && rpn_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
